// ===== rtl/sset_pkg.sv =====
`timescale 1ns / 1ps

package sset_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COUNT_BITS = 32;
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 48;
  localparam int SQ_W       = 31;
  localparam int SQSUM_W    = 63;
  localparam int MEAN_W     = 32;
  localparam int DEV_W      = 24;
  localparam int STATUS_W   = 2;
  localparam int FRAC_W     = 16;

  // shared add/sub unit and sequencer sizing
  localparam int ACC_W      = 112;
  localparam int DIV_W      = 64;
  localparam int STEP_W     = $clog2(ACC_W);
  localparam int SQRT_STEPS = 32;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'((65'd1 << COUNT_BITS) - 65'd1);

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SINGLE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT    = 2'd2;

endpackage

// ===== rtl/sset_ifs.sv =====
`timescale 1ns / 1ps

interface sset_in_if import sset_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface sset_out_if import sset_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic        [CNT_W-1:0]    sample_count;
  logic signed [SAMPLE_W-1:0] minimum;
  logic signed [SAMPLE_W-1:0] maximum;
  logic signed [SUM_W-1:0]    total;
  logic signed [MEAN_W-1:0]   mean_q16;
  logic        [DEV_W-1:0]    deviation_q8;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, output sample_count, output minimum, output maximum,
                  output total, output mean_q16, output deviation_q8, output status,
                  input ready);
  modport sink   (input valid, input sample_count, input minimum, input maximum,
                  input total, input mean_q16, input deviation_q8, input status,
                  output ready);
endinterface

// ===== rtl/sample_set_statistics_core.sv =====
`timescale 1ns / 1ps
// channel   direction  beat contents
// in_chan   in         sample, last
// out_chan  out        sample_count, minimum, maximum, total, mean_q16, deviation_q8, status
//
// a sample without last is accepted, then accumulated
// the last sample runs S_LAST, S_DMUL, S_VMUL, S_VSUB, S_VDIV, S_SQRT, S_MDIV for a set
// of two or more, S_LAST, S_MDIV for one sample; all steps share one 112-bit add/sub unit
// reset is synchronous, with no clearing pass
// the result sits in an output register; samples of the next set are taken while it waits,
// and a finished set waits in S_IDLE until that register is free

module sample_set_statistics_core import sset_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  sset_in_if.sink       in_chan,
  sset_out_if.source    out_chan
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_ACC  = 9'b000000010,
    S_LAST = 9'b000000100,
    S_DMUL = 9'b000001000,
    S_VMUL = 9'b000010000,
    S_VSUB = 9'b000100000,
    S_VDIV = 9'b001000000,
    S_SQRT = 9'b010000000,
    S_MDIV = 9'b100000000
  } sset_state_t;

  // pend_r: a finished set waits in S_IDLE for the output register
  sset_state_t                state_r, state_nxt;
  logic                       pend_r, pend_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic [ACC_W-1:0]           mc_r, mc_nxt;
  logic [SUM_W-1:0]           mq_r, mq_nxt;
  logic [DIV_W-1:0]           div_r, div_nxt;
  logic [DEV_W-1:0]           dev_r, dev_nxt;
  logic [MEAN_W-1:0]          mean_r, mean_nxt;

  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                       last_r, last_nxt;
  logic [SQ_W-1:0]            sq_r, sq_nxt;

  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [SQSUM_W-1:0]         sqsum_r, sqsum_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic                       sat_r, sat_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]           o_cnt_r, o_cnt_nxt;
  logic signed [SAMPLE_W-1:0] o_min_r, o_min_nxt;
  logic signed [SAMPLE_W-1:0] o_max_r, o_max_nxt;
  logic [SUM_W-1:0]           o_sum_r, o_sum_nxt;
  logic [MEAN_W-1:0]          o_mean_r, o_mean_nxt;
  logic [DEV_W-1:0]           o_dev_r, o_dev_nxt;
  logic [STATUS_W-1:0]        o_status_r, o_status_nxt;

  logic                       in_beat;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [SUM_W-1:0]           mag;
  logic [CNT_W-1:0]           cnt_dec;
  logic [ACC_W-1:0]           trial_rem;
  logic [ACC_W-1:0]           sqrt_bit;
  logic [ACC_W-1:0]           op_a, op_b;
  logic                       op_sub;
  logic [ACC_W:0]             sum_w;
  logic [ACC_W-1:0]           add_res;
  logic                       no_borrow;
  logic [ACC_W-1:0]           quot;
  logic [ACC_W-1:0]           root;
  logic [STATUS_W-1:0]        status_now;
  logic                       out_free;

  assign in_chan.ready  = (state_r == S_IDLE) && !pend_r;
  assign in_beat        = in_chan.valid && in_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.sample_count = o_cnt_r;
  assign out_chan.minimum      = o_min_r;
  assign out_chan.maximum      = o_max_r;
  assign out_chan.total        = o_sum_r;
  assign out_chan.mean_q16     = o_mean_r;
  assign out_chan.deviation_q8 = o_dev_r;
  assign out_chan.status       = o_status_r;

  assign sq_full   = in_chan.sample * in_chan.sample;
  assign mag       = sum_r[SUM_W-1] ? (SUM_W'(0) - sum_r) : sum_r;
  assign cnt_dec   = cnt_r - 1'b1;
  assign trial_rem = {acc_r[ACC_W-2:0], mc_r[ACC_W-1]};
  assign sqrt_bit  = ACC_W'(1) << {step_r, 1'b0};
  assign out_free  = !out_valid_r || out_chan.ready;

  assign status_now = sat_r ? STATUS_SAT :
                      ((cnt_r < CNT_W'(2)) ? STATUS_SINGLE : STATUS_OK);

  // shared add/sub unit
  always_comb begin
    op_a   = acc_r;
    op_b   = '0;
    op_sub = 1'b0;
    unique case (state_r)
      S_DMUL, S_VMUL: begin
        op_b = mq_r[0] ? mc_r : '0;
      end
      S_VSUB: begin
        op_b   = mq_r[0] ? mc_r : '0;
        op_sub = 1'b1;
      end
      S_VDIV, S_MDIV: begin
        op_a   = trial_rem;
        op_b   = ACC_W'(div_r);
        op_sub = 1'b1;
      end
      S_SQRT: begin
        op_b   = mc_r | sqrt_bit;
        op_sub = 1'b1;
      end
      default: begin
        op_b = '0;
      end
    endcase
    sum_w = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (ACC_W+1)'(op_sub);
  end

  assign add_res   = sum_w[ACC_W-1:0];
  assign no_borrow = sum_w[ACC_W];
  assign quot      = {mc_r[ACC_W-2:0], no_borrow};
  assign root      = no_borrow ? ((mc_r >> 1) | sqrt_bit) : (mc_r >> 1);

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    mc_nxt        = mc_r;
    mq_nxt        = mq_r;
    div_nxt       = div_r;
    dev_nxt       = dev_r;
    mean_nxt      = mean_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    sq_nxt        = sq_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    sqsum_nxt     = sqsum_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;
    o_cnt_nxt     = o_cnt_r;
    o_min_nxt     = o_min_r;
    o_max_nxt     = o_max_r;
    o_sum_nxt     = o_sum_r;
    o_mean_nxt    = o_mean_r;
    o_dev_nxt     = o_dev_r;
    o_status_nxt  = o_status_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (pend_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            o_cnt_nxt     = cnt_r;
            o_min_nxt     = min_r;
            o_max_nxt     = max_r;
            o_sum_nxt     = sum_r;
            o_mean_nxt    = mean_r;
            o_dev_nxt     = dev_r;
            o_status_nxt  = status_now;
            pend_nxt      = 1'b0;
            cnt_nxt       = '0;
            sum_nxt       = '0;
            sqsum_nxt     = '0;
            min_nxt       = SAMPLE_MAX;
            max_nxt       = SAMPLE_MIN;
            sat_nxt       = 1'b0;
          end
        end else if (in_beat) begin
          sample_nxt = in_chan.sample;
          last_nxt   = in_chan.last;
          sq_nxt     = sq_full[SQ_W-1:0];
          state_nxt  = S_ACC;
        end
      end
      S_ACC: begin
        if (sample_r < min_r) min_nxt = sample_r;
        if (sample_r > max_r) max_nxt = sample_r;
        if (cnt_r == CNT_LIMIT) begin
          sat_nxt = 1'b1;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          sum_nxt   = sum_r + {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
          sqsum_nxt = sqsum_r + SQSUM_W'(sq_r);
        end
        state_nxt = last_r ? S_LAST : S_IDLE;
      end
      S_LAST: begin
        dev_nxt = '0;
        acc_nxt = '0;
        if (cnt_r >= CNT_W'(2)) begin
          mc_nxt    = ACC_W'(cnt_dec);
          mq_nxt    = SUM_W'(cnt_r);
          step_nxt  = STEP_W'(CNT_W - 1);
          state_nxt = S_DMUL;
        end else begin
          mc_nxt    = ACC_W'({mag, {FRAC_W{1'b0}}});
          div_nxt   = DIV_W'(cnt_r);
          step_nxt  = STEP_W'(ACC_W - 1);
          state_nxt = S_MDIV;
        end
      end
      S_DMUL: begin
        acc_nxt  = add_res;
        mc_nxt   = mc_r << 1;
        mq_nxt   = mq_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          div_nxt   = add_res[DIV_W-1:0];
          acc_nxt   = '0;
          mc_nxt    = ACC_W'(sqsum_r);
          mq_nxt    = SUM_W'(cnt_r);
          step_nxt  = STEP_W'(CNT_W - 1);
          state_nxt = S_VMUL;
        end
      end
      S_VMUL: begin
        acc_nxt  = add_res;
        mc_nxt   = mc_r << 1;
        mq_nxt   = mq_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          mc_nxt    = ACC_W'(mag);
          mq_nxt    = mag;
          step_nxt  = STEP_W'(SUM_W - 1);
          state_nxt = S_VSUB;
        end
      end
      S_VSUB: begin
        acc_nxt  = add_res;
        mc_nxt   = mc_r << 1;
        mq_nxt   = mq_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          acc_nxt   = '0;
          mc_nxt    = {add_res[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
          step_nxt  = STEP_W'(ACC_W - 1);
          state_nxt = S_VDIV;
        end
      end
      S_VDIV: begin
        acc_nxt  = no_borrow ? add_res : trial_rem;
        mc_nxt   = quot;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          acc_nxt   = ACC_W'(quot[DIV_W-1:0]);
          mc_nxt    = '0;
          step_nxt  = STEP_W'(SQRT_STEPS - 1);
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (no_borrow) acc_nxt = add_res;
        mc_nxt   = root;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          dev_nxt   = root[DEV_W-1:0];
          acc_nxt   = '0;
          mc_nxt    = ACC_W'({mag, {FRAC_W{1'b0}}});
          div_nxt   = DIV_W'(cnt_r);
          step_nxt  = STEP_W'(ACC_W - 1);
          state_nxt = S_MDIV;
        end
      end
      S_MDIV: begin
        acc_nxt  = no_borrow ? add_res : trial_rem;
        mc_nxt   = quot;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          mean_nxt  = sum_r[SUM_W-1] ? (MEAN_W'(0) - quot[MEAN_W-1:0]) : quot[MEAN_W-1:0];
          pend_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      sum_r       <= '0;
      sqsum_r     <= '0;
      min_r       <= SAMPLE_MAX;
      max_r       <= SAMPLE_MIN;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      sqsum_r     <= sqsum_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    acc_r      <= acc_nxt;
    mc_r       <= mc_nxt;
    mq_r       <= mq_nxt;
    div_r      <= div_nxt;
    dev_r      <= dev_nxt;
    mean_r     <= mean_nxt;
    sample_r   <= sample_nxt;
    last_r     <= last_nxt;
    sq_r       <= sq_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_min_r    <= o_min_nxt;
    o_max_r    <= o_max_nxt;
    o_sum_r    <= o_sum_nxt;
    o_mean_r   <= o_mean_nxt;
    o_dev_r    <= o_dev_nxt;
    o_status_r <= o_status_nxt;
  end

endmodule
